[src/stsw_pkg.sv]
// Shared types and constants for the sparse triangular solve window.
// No dependencies; imported by every module of the block.
`default_nettype none
package stsw_pkg;

  localparam int WINDOW = 1024;
  localparam int ROW_W  = 10;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_NODE = 2'd1,
    FUNC_EDGE = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  typedef enum logic {
    FOP_MUL = 1'b0,
    FOP_SUB = 1'b1
  } fop_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MWAIT,
    ST_MDONE,
    ST_SWAIT,
    ST_SDONE,
    ST_RESP
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [ROW_W-1:0]   row_index;
    logic [ROW_W-1:0]   col_index;
    logic [WORD_W-1:0]  operand_bits;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0]  solution_bits;
    logic [ROW_W-1:0]   solution_row;
  } out_beat_t;

  // Request into the shared floating-point unit.
  typedef struct packed {
    logic              start;
    fop_t              op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } fpu_req_t;

endpackage
`default_nettype wire

[src/stsw_fpu.sv]
// Shared single-precision unit: a*b or a-b, round to nearest even.
// Stage 1 multiplies or aligns/adds, stage 2 normalizes and rounds. Uses stsw_pkg.
`default_nettype none
module stsw_fpu
  import stsw_pkg::*;
(
  input  wire logic        clk,
  input  wire fpu_req_t    req,
  output logic [WORD_W-1:0] result
);

  localparam logic [31:0] QNAN_DEF = 32'hFFC0_0000;

  function automatic logic [31:0] round_pack(input logic s, input logic [49:0] w,
                                             input logic signed [11:0] k);
    logic [5:0]         lz;
    logic [49:0]        t;
    logic [49:0]        u;
    logic signed [11:0] e;
    logic signed [11:0] rs_full;
    logic [5:0]         rs;
    logic               st;
    logic [24:0]        m;
    logic               up;
    logic [31:0]        r;
    lz = '0;
    for (int i = 0; i < 50; i++) begin
      if (w[i]) lz = 6'(49 - i);
    end
    t = w << lz;
    e = k + 12'sd176 - $signed({6'b0, lz});
    u = t;
    st = 1'b0;
    if (e < 12'sd1) begin
      rs_full = 12'sd1 - e;
      rs = (rs_full > 12'sd50) ? 6'd50 : rs_full[5:0];
      u  = t >> rs;
      st = |(t & ((50'd1 << rs) - 50'd1));
    end
    m  = {1'b0, u[49:26]};
    up = u[25] & (st | (|u[24:0]) | m[0]);
    m  = m + 25'(up);
    if (e < 12'sd1) begin
      r = {s, 7'd0, m[23], m[22:0]};
    end else begin
      if (m[24]) begin
        m = m >> 1;
        e = e + 12'sd1;
      end
      if (e >= 12'sd255) r = {s, 8'hFF, 23'd0};
      else               r = {s, e[7:0], m[22:0]};
    end
    if (w == '0) r = {s, 31'd0};
    return r;
  endfunction

  logic        sa, sb;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic [8:0]  eae, ebe;
  logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;

  assign sa = req.a[31];
  assign sb = req.b[31];
  assign ea = req.a[30:23];
  assign eb = req.b[30:23];
  assign fa = req.a[22:0];
  assign fb = req.b[22:0];
  assign ma = {ea != 8'd0, fa};
  assign mb = {eb != 8'd0, fb};
  assign eae = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
  assign ebe = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
  assign nan_a = (ea == 8'hFF) && (fa != '0);
  assign nan_b = (eb == 8'hFF) && (fb != '0);
  assign inf_a = (ea == 8'hFF) && (fa == '0);
  assign inf_b = (eb == 8'hFF) && (fb == '0);
  assign zer_a = req.a[30:0] == '0;
  assign zer_b = req.b[30:0] == '0;

  logic               s1_spec_nxt, s1_sign_nxt;
  logic [31:0]        s1_val_nxt;
  logic [49:0]        s1_w_nxt;
  logic signed [11:0] s1_k_nxt;

  logic               s1_spec_r, s1_sign_r;
  logic [31:0]        s1_val_r;
  logic [49:0]        s1_w_r;
  logic signed [11:0] s1_k_r;
  logic [31:0]        result_r;

  // subtract path: b's sign flipped, larger magnitude taken as base
  logic        a_big, s_big, s_sml, same;
  logic [23:0] m_big, m_sml;
  logic [8:0]  e_big, e_sml, d;
  logic [49:0] sml_w, sml_sh, big_w, sum_w;
  logic        jam;

  always_comb begin
    a_big = req.a[30:0] >= req.b[30:0];
    s_big = a_big ? sa : ~sb;
    s_sml = a_big ? ~sb : sa;
    m_big = a_big ? ma : mb;
    m_sml = a_big ? mb : ma;
    e_big = a_big ? eae : ebe;
    e_sml = a_big ? ebe : eae;
    d     = e_big - e_sml;
    same  = s_big == s_sml;
    big_w = {1'b0, m_big, 25'd0};
    sml_w = {1'b0, m_sml, 25'd0};
    if (d >= 9'd50) begin
      sml_sh = '0;
      jam    = |m_sml;
    end else begin
      sml_sh = sml_w >> d[5:0];
      jam    = |(sml_w & ((50'd1 << d[5:0]) - 50'd1));
    end
    sml_sh[0] = sml_sh[0] | jam;
    sum_w = same ? (big_w + sml_sh) : (big_w - sml_sh);
  end

  always_comb begin
    s1_spec_nxt = 1'b0;
    s1_val_nxt  = '0;
    if (req.op == FOP_MUL) begin
      s1_w_nxt    = {2'b0, 48'(ma) * 48'(mb)};
      s1_k_nxt    = $signed({3'b0, eae}) + $signed({3'b0, ebe}) - 12'sd300;
      s1_sign_nxt = sa ^ sb;
      if (nan_a) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = req.a | 32'h0040_0000;
      end else if (nan_b) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = req.b | 32'h0040_0000;
      end else if ((inf_a && zer_b) || (inf_b && zer_a)) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = QNAN_DEF;
      end else if (inf_a || inf_b) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = {sa ^ sb, 8'hFF, 23'd0};
      end
    end else begin
      s1_w_nxt    = sum_w;
      s1_k_nxt    = $signed({3'b0, e_big}) - 12'sd175;
      s1_sign_nxt = (sum_w == '0) ? (same & s_big) : s_big;
      if (nan_a) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = req.a | 32'h0040_0000;
      end else if (nan_b) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = req.b | 32'h0040_0000;
      end else if (inf_a && inf_b && (sa == sb)) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = QNAN_DEF;
      end else if (inf_a) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = req.a;
      end else if (inf_b) begin
        s1_spec_nxt = 1'b1;
        s1_val_nxt  = {~sb, 8'hFF, 23'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      s1_spec_r <= s1_spec_nxt;
      s1_val_r  <= s1_val_nxt;
      s1_w_r    <= s1_w_nxt;
      s1_k_r    <= s1_k_nxt;
      s1_sign_r <= s1_sign_nxt;
    end
    result_r <= s1_spec_r ? s1_val_r : round_pack(s1_sign_r, s1_w_r, s1_k_r);
  end

  assign result = result_r;

endmodule
`default_nettype wire

[src/sparse_triangular_solve_window.sv]
// Item states: load IDLE; read RESP; node MUL, MWAIT, MDONE; edge those plus SWAIT, SDONE.
// A read offers its result beat the cycle after it is accepted; out_ready stalls add to it.
// Throughput: one item at a time; the shared FP unit (multiply, then subtract
// for an edge) and the sequencer set the item time.
// Reset (rst_n, synchronous) clears only the sequencer; the rhs and solution
// stores power up undefined and need a write before their first read.
// Depends on stsw_pkg and stsw_fpu.
`default_nettype none
module sparse_triangular_solve_window
  import stsw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  state_t state_r, state_nxt;
  in_beat_t item_r;

  logic [WORD_W-1:0] rhs_mem [WINDOW];
  logic [WORD_W-1:0] sol_mem [WINDOW];
  logic [WORD_W-1:0] rhs_q_r, sol_q_r;

  logic accept;
  logic row_ok, col_ok;
  logic [ROW_W-1:0] sol_raddr;
  logic rhs_we, sol_we;
  logic [WORD_W-1:0] rhs_wdata;

  fpu_req_t fpu_req;
  logic [WORD_W-1:0] fpu_res;

  assign accept    = in_valid && in_ready;
  assign row_ok    = 32'(in_data.row_index) < WINDOW;
  assign col_ok    = 32'(item_r.col_index) < WINDOW;
  assign sol_raddr = (in_data.func == FUNC_EDGE) ? in_data.col_index : in_data.row_index;

  // --- next state ---
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FUNC_LOAD: state_nxt = ST_IDLE;
            FUNC_NODE: state_nxt = row_ok ? ST_MUL : ST_IDLE;
            FUNC_EDGE: state_nxt = row_ok ? ST_MUL : ST_IDLE;
            FUNC_READ: state_nxt = ST_RESP;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_nxt = ST_MWAIT;
      ST_MWAIT: state_nxt = ST_MDONE;
      ST_MDONE: state_nxt = (item_r.func == FUNC_EDGE) ? ST_SWAIT : ST_IDLE;
      ST_SWAIT: state_nxt = ST_SDONE;
      ST_SDONE: state_nxt = ST_IDLE;
      ST_RESP:  state_nxt = out_ready ? ST_IDLE : ST_RESP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // --- outputs of the sequencer ---
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    fpu_req   = '{start: 1'b0, op: FOP_MUL, a: '0, b: '0};
    rhs_we    = 1'b0;
    rhs_wdata = fpu_res;
    sol_we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        rhs_we    = accept && (in_data.func == FUNC_LOAD) && row_ok;
        rhs_wdata = in_data.operand_bits;
      end
      ST_MUL: begin
        // node: rhs * recip; edge: sol[col] * coeff
        fpu_req.start = 1'b1;
        fpu_req.op    = FOP_MUL;
        fpu_req.a     = (item_r.func == FUNC_NODE) ? rhs_q_r : sol_q_r;
        fpu_req.b     = item_r.operand_bits;
      end
      ST_MDONE: begin
        sol_we        = (item_r.func == FUNC_NODE);
        // edge: rhs - product; out-of-window column leaves rhs alone
        fpu_req.start = (item_r.func == FUNC_EDGE);
        fpu_req.op    = FOP_SUB;
        fpu_req.a     = rhs_q_r;
        fpu_req.b     = fpu_res;
      end
      ST_SDONE: begin
        rhs_we = col_ok;
      end
      ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
  end

  // rhs store: one write port, one registered read
  always_ff @(posedge clk) begin
    if (rhs_we) rhs_mem[(state_r == ST_IDLE) ? in_data.row_index : item_r.row_index] <= rhs_wdata;
    if (accept) rhs_q_r <= rhs_mem[in_data.row_index];
  end

  // solution store: the registered read also feeds the result beat
  always_ff @(posedge clk) begin
    if (sol_we) sol_mem[item_r.row_index] <= fpu_res;
    if (accept) sol_q_r <= sol_mem[sol_raddr];
  end

  assign out_data.solution_bits = sol_q_r;
  assign out_data.solution_row  = item_r.row_index;

  stsw_fpu u_fpu (
    .clk    (clk),
    .req    (fpu_req),
    .result (fpu_res)
  );

endmodule
`default_nettype wire

[src/stsw_checker.sv]
// Port-level checks for sparse_triangular_solve_window, attached by bind.
// Depends on stsw_pkg.
`default_nettype none
module stsw_checker
  import stsw_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_beat_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FUNC_READ)
    |=> out_valid && (out_data.solution_row == $past(in_data.row_index)))
    else $error("read beat without its result");

  a_no_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func != FUNC_READ) |=> !out_valid)
    else $error("result from a non-read beat");

endmodule

bind sparse_triangular_solve_window stsw_checker u_stsw_checker (.*);
`default_nettype wire

[sim/sparse_triangular_solve_window_test.sv]
// Self-checking testbench for sparse_triangular_solve_window: drives load, node,
// edge and read beats and checks every read beat against an internal predictor.
// Depends on stsw_pkg and the sparse_triangular_solve_window RTL.
`default_nettype none
module sparse_triangular_solve_window_test;
  import stsw_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no beat on either side
  localparam int ITEM_TARGET = 850;

  // Keeps a copy of both stores, predicts each read beat and checks it.
  class solve_scoreboard;
    bit [WORD_W-1:0] rhs_mem[WINDOW];
    bit [WORD_W-1:0] sol_mem[WINDOW];
    out_beat_t       reads_due[$];
    int              mismatches;
    int              reads_checked;
    int              kind_count[4];

    // Widen single to double; exact for every class of value.
    function real single_to_real(bit [31:0] f);
      bit [23:0] mant;
      int        ex;
      if (f[30:23] == 8'hff)
        return $bitstoreal({f[31], 11'h7ff, f[22:0], 29'b0});
      if (f[30:23] == 8'h00) begin
        if (f[22:0] == 0) return $bitstoreal({f[31], 63'b0});
        mant = {1'b0, f[22:0]};
        ex = -126;
        while (!mant[23]) begin
          mant = mant << 1;
          ex--;
        end
        return $bitstoreal({f[31], 11'(ex + 1023), mant[22:0], 29'b0});
      end
      return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0});
    endfunction

    // Round a double to single, nearest even, with subnormals and overflow.
    function bit [31:0] real_to_single(real r);
      bit [63:0] d;
      bit [63:0] sig;
      bit [63:0] kept;
      int        fe;
      int        sh;
      bit        rnd;
      bit        sticky;
      d = $realtobits(r);
      if (d[62:52] == 11'h7ff)
        return (d[51:0] == 0) ? {d[63], 8'hff, 23'b0}
                              : {d[63], 8'hff, 1'b1, d[50:29]};
      if (d[62:52] == 0) return {d[63], 31'b0};
      sig = {11'b0, 1'b1, d[51:0]};
      fe = int'(d[62:52]) - 1023 + 127;
      sh = 29 + ((fe < 1) ? (1 - fe) : 0);
      if (sh > 60) return {d[63], 31'b0};
      kept = sig >> sh;
      rnd = sig[sh-1];
      sticky = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
      if (rnd && (sticky || kept[0])) kept++;
      if (fe < 1) return {d[63], kept[30:0]};  // subnormal, may round up to normal
      if (kept[24]) begin
        kept = kept >> 1;
        fe++;
      end
      if (fe >= 255) return {d[63], 8'hff, 23'b0};
      return {d[63], 8'(fe), kept[22:0]};
    endfunction

    function bit [31:0] mul_single(bit [31:0] a, bit [31:0] b);
      return real_to_single(single_to_real(a) * single_to_real(b));
    endfunction

    function bit [31:0] sub_single(bit [31:0] a, bit [31:0] b);
      return real_to_single(single_to_real(a) - single_to_real(b));
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t rd;
      kind_count[b.func]++;
      case (b.func)
        FUNC_LOAD: rhs_mem[b.row_index] = b.operand_bits;
        FUNC_NODE: sol_mem[b.row_index] = mul_single(rhs_mem[b.row_index], b.operand_bits);
        FUNC_EDGE: begin
          rhs_mem[b.row_index] = sub_single(rhs_mem[b.row_index],
              mul_single(sol_mem[b.col_index], b.operand_bits));
        end
        default: begin
          rd.solution_bits = sol_mem[b.row_index];
          rd.solution_row = b.row_index;
          reads_due.push_back(rd);
        end
      endcase
    endfunction

    function bit is_nan(bit [31:0] f);
      return f[30:23] == 8'hff && f[22:0] != 0;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (reads_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: row %0d bits %h",
                   got.solution_row, got.solution_bits);
        return;
      end
      want = reads_due.pop_front();
      reads_checked++;
      // NaN payloads are not pinned down; any NaN matches any NaN
      if (got.solution_row != want.solution_row ||
          (got.solution_bits != want.solution_bits &&
           !(is_nan(got.solution_bits) && is_nan(want.solution_bits)))) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected row %0d bits %h, got row %0d bits %h",
                   want.solution_row, want.solution_bits,
                   got.solution_row, got.solution_bits);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  sparse_triangular_solve_window i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  solve_scoreboard sb = new();

  // Which entries the stimulus has written; only written entries are ever read.
  bit rhs_written[WINDOW];
  bit sol_written[WINDOW];
  int items_sent;
  int burst_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Accepted beats go straight to the scoreboard; sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: too long with no beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sparse_triangular_solve_window test failed");
        $finish;
      end
    end
  end

  // Receiver stalls: the pattern is redrawn periodically among always ready,
  // coin toss, mostly stalled and a fixed 1-in-3 comb.
  int ready_mode;
  int ready_tick;
  always @(negedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 64 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= (ready_tick % 3 == 0);
    endcase
  end

  // Operand: specials now and then, mostly values of moderate size so that
  // chains of edges stay finite, sometimes raw bits.
  function automatic bit [31:0] pick_operand();
    bit [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                32'hff80_0000, 32'h7fc0_0000, 32'h0000_0001,
                                32'h807f_ffff, 32'h7f7f_ffff, 32'h0080_0000,
                                32'h3f80_0000};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return specials[$urandom_range(0, 9)];
    if (sel == 1) return $urandom;
    return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
  endfunction

  task automatic push_item(bit [1:0] f, int row, int col, bit [31:0] opnd);
    in_beat_t b;
    int gap;
    b.func = func_t'(f);
    b.row_index = row[ROW_W-1:0];
    b.col_index = col[ROW_W-1:0];
    b.operand_bits = opnd;
    if (f == FUNC_LOAD) rhs_written[row] = 1'b1;
    if (f == FUNC_NODE) sol_written[row] = 1'b1;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  // One level-scheduled chain on a handful of rows: load every rhs, solve the
  // first row, then eliminate edges from solved rows before each next node.
  task automatic push_chain();
    int rows[6];
    int n;
    int k;
    n = $urandom_range(2, 6);
    for (int i = 0; i < n; i++) rows[i] = $urandom_range(0, WINDOW - 1);
    for (int i = 0; i < n; i++) push_item(FUNC_LOAD, rows[i], $urandom, pick_operand());
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, i);
      for (int j = 0; j < k; j++)
        push_item(FUNC_EDGE, rows[i], rows[$urandom_range(0, i - 1)], pick_operand());
      push_item(FUNC_NODE, rows[i], $urandom, pick_operand());
      if ($urandom_range(0, 2) == 0) push_item(FUNC_READ, rows[i], $urandom, $urandom);
    end
    push_item(FUNC_READ, rows[n-1], $urandom, $urandom);
  endtask

  // A lone legal item on any row; falls back to a load when nothing fits.
  task automatic push_noise();
    int row;
    int col;
    int kind;
    row = $urandom_range(0, WINDOW - 1);
    col = $urandom_range(0, WINDOW - 1);
    kind = $urandom_range(0, 3);
    if (kind == FUNC_NODE && rhs_written[row])
      push_item(FUNC_NODE, row, col, pick_operand());
    else if (kind == FUNC_EDGE && rhs_written[row] && sol_written[col])
      push_item(FUNC_EDGE, row, col, pick_operand());
    else if (kind == FUNC_READ && sol_written[row])
      push_item(FUNC_READ, row, col, $urandom);
    else
      push_item(FUNC_LOAD, row, col, pick_operand());
  endtask

  initial begin
    bit paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    ready_mode = 0;
    ready_tick = 0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme rows and columns, zeros of both signs, infinities,
    // NaN, subnormals, overflow, and infinity times zero.
    push_item(FUNC_LOAD, 0, 1023, 32'h3f80_0000);
    push_item(FUNC_LOAD, 1023, 0, 32'h7f7f_ffff);
    push_item(FUNC_NODE, 0, 0, 32'h3f00_0000);
    push_item(FUNC_READ, 0, 1023, 32'hffff_ffff);
    push_item(FUNC_NODE, 1023, 1023, 32'h4000_0000);   // overflows to infinity
    push_item(FUNC_READ, 1023, 0, 32'h0);
    push_item(FUNC_LOAD, 5, 0, 32'h7f80_0000);
    push_item(FUNC_LOAD, 6, 0, 32'h7fc0_0001);
    push_item(FUNC_EDGE, 5, 0, 32'h0000_0001);        // subnormal coefficient
    push_item(FUNC_NODE, 5, 0, 32'h0000_0000);        // infinity times zero
    push_item(FUNC_READ, 5, 0, 32'h0);
    push_item(FUNC_EDGE, 6, 1023, 32'hffff_ffff);
    push_item(FUNC_NODE, 6, 0, 32'h3f80_0000);
    push_item(FUNC_READ, 6, 0, 32'h0);
    push_item(FUNC_LOAD, 7, 0, 32'h8000_0000);
    push_item(FUNC_NODE, 7, 0, 32'h0080_0000);        // negative zero stays
    push_item(FUNC_READ, 7, 0, 32'h0);
    push_item(FUNC_LOAD, 8, 0, 32'h0080_0000);
    push_item(FUNC_NODE, 8, 0, 32'h3e80_0000);        // underflows to subnormal
    push_item(FUNC_EDGE, 1023, 8, 32'h8080_0000);
    push_item(FUNC_NODE, 1023, 0, 32'h3f80_0000);
    push_item(FUNC_READ, 8, 0, 32'h0);
    push_item(FUNC_READ, 1023, 0, 32'h0);

    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent > ITEM_TARGET / 2) begin
        // drain every pending read before going on
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.reads_due.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) push_noise();
      else push_chain();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.reads_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items: %0d loads, %0d nodes, %0d edges, %0d reads",
             items_sent, sb.kind_count[FUNC_LOAD], sb.kind_count[FUNC_NODE],
             sb.kind_count[FUNC_EDGE], sb.kind_count[FUNC_READ]);
    $display("%0d read beats checked, %0d mismatches", sb.reads_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("sparse_triangular_solve_window test passed");
    end else begin
      $display("sparse_triangular_solve_window test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
